@@ design/sws_pkg.sv @@
// Shared types and constants for the shell word splitter.
// Holds the lexer modes, result codes, result word layout and word limit.
// No dependencies; every other design file uses it by scoped names.
package sws_pkg;

	// One more than the largest number of words a command may hold.
	localparam int MAX_WORDS = 4096;

	localparam int WIDX_W = 12;

	// Word count at which a further word end is refused as too many.
	localparam logic [WIDX_W:0] WORD_LIMIT = (WIDX_W + 1)'(MAX_WORDS - 1);

	// Byte values that steer the lexer.
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;

	// Result kinds.
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// Command status codes.
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_UNBALANCED = 2'd1;
	localparam logic [1:0] ST_EMPTY      = 2'd2;
	localparam logic [1:0] ST_TOO_MANY   = 2'd3;

	// Lexer modes. Codes 5 to 7 never arise and behave as plain.
	typedef enum logic [2:0] {
		MODE_PLAIN  = 3'd0,
		MODE_SQ     = 3'd1,
		MODE_DQ     = 3'd2,
		MODE_DQ_ESC = 3'd3,
		MODE_ESC    = 3'd4
	} lex_mode_t;

	// Lexer state carried from word to word.
	typedef struct packed {
		lex_mode_t          mode;
		logic               word_open;
		logic [WIDX_W-1:0]  word_count;
		logic [1:0]         error_code;
	} lex_state_t;

	// One result word on the output channel.
	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         out_byte;
		logic [WIDX_W-1:0]  word_index;
		logic [1:0]         status;
		logic               last;
	} result_t;

	// Largest number of results one input word can cause.
	localparam int MAX_RESULTS = 3;

	function automatic result_t make_result(logic [1:0] kind, logic [7:0] b,
			logic [WIDX_W-1:0] idx, logic [1:0] st, logic lst);
		result_t r;
		r.kind       = kind;
		r.out_byte   = b;
		r.word_index = idx;
		r.status     = st;
		r.last       = lst;
		return r;
	endfunction

endpackage

@@ design/sws_lexer.sv @@
// Next-state and result logic of the shell word splitter.
// Depends on sws_pkg for the lexer state, modes and result layout.
// Purely combinational; the top level holds all registers.
module sws_lexer (
	input  logic [7:0]           ch,
	input  logic                 is_end,
	input  sws_pkg::lex_state_t  cur,
	output sws_pkg::lex_state_t  nxt,
	output sws_pkg::result_t     res [sws_pkg::MAX_RESULTS],
	output logic [1:0]           res_cnt
);

	logic [1:0]                  err;
	logic [sws_pkg::WIDX_W-1:0]  wc;
	logic [1:0]                  n;
	logic                        at_limit;
	logic                        is_sep;

	assign at_limit = {1'b0, cur.word_count} >= sws_pkg::WORD_LIMIT;
	assign is_sep   = (ch == sws_pkg::CH_SPACE) || (ch == sws_pkg::CH_TAB) ||
		(ch == sws_pkg::CH_LF) || (ch == sws_pkg::CH_CR);

	// Work out the results and the next state for one input word.
	always_comb begin
		nxt = cur;
		err = cur.error_code;
		wc  = cur.word_count;
		n   = 2'd0;
		for (int i = 0; i < sws_pkg::MAX_RESULTS; i++) begin
			res[i] = '0;
		end

		if (is_end) begin
			// Terminator: flush a pending word, then report the status.
			if (err == sws_pkg::ST_OK) begin
				if (cur.mode == sws_pkg::MODE_SQ || cur.mode == sws_pkg::MODE_DQ ||
						cur.mode == sws_pkg::MODE_DQ_ESC) begin
					err = sws_pkg::ST_UNBALANCED;
				end else begin
					if (cur.mode == sws_pkg::MODE_ESC) begin
						res[n] = sws_pkg::make_result(sws_pkg::KIND_BYTE,
							sws_pkg::CH_BACKSLASH, wc, sws_pkg::ST_OK, 1'b0);
						n = n + 2'd1;
					end
					if (cur.word_open) begin
						if (at_limit) begin
							err = sws_pkg::ST_TOO_MANY;
						end else begin
							res[n] = sws_pkg::make_result(sws_pkg::KIND_END, 8'd0, wc,
								sws_pkg::ST_OK, 1'b0);
							n  = n + 2'd1;
							wc = wc + 1'b1;
						end
					end
					if (err == sws_pkg::ST_OK && wc == '0) begin
						err = sws_pkg::ST_EMPTY;
					end
				end
			end
			res[n] = sws_pkg::make_result(sws_pkg::KIND_DONE, 8'd0,
				(err == sws_pkg::ST_OK) ? wc : '0, err, 1'b1);
			n = n + 2'd1;
			nxt.mode       = sws_pkg::MODE_PLAIN;
			nxt.word_open  = 1'b0;
			nxt.word_count = '0;
			nxt.error_code = sws_pkg::ST_OK;
		end else if (cur.error_code == sws_pkg::ST_OK) begin
			// Ordinary byte: step the lexer.
			unique case (cur.mode)
				sws_pkg::MODE_SQ: begin
					if (ch == sws_pkg::CH_SQUOTE) begin
						nxt.mode = sws_pkg::MODE_PLAIN;
					end else begin
						nxt.word_open = 1'b1;
						n = 2'd1;
					end
				end
				sws_pkg::MODE_DQ: begin
					if (ch == sws_pkg::CH_DQUOTE) begin
						nxt.mode = sws_pkg::MODE_PLAIN;
					end else if (ch == sws_pkg::CH_BACKSLASH) begin
						nxt.mode = sws_pkg::MODE_DQ_ESC;
					end else begin
						nxt.word_open = 1'b1;
						n = 2'd1;
					end
				end
				sws_pkg::MODE_DQ_ESC: begin
					nxt.mode      = sws_pkg::MODE_DQ;
					nxt.word_open = 1'b1;
					n = 2'd1;
				end
				sws_pkg::MODE_ESC: begin
					nxt.mode      = sws_pkg::MODE_PLAIN;
					nxt.word_open = 1'b1;
					n = 2'd1;
				end
				default: begin
					nxt.mode = sws_pkg::MODE_PLAIN;
					if (ch == sws_pkg::CH_SQUOTE) begin
						nxt.word_open = 1'b1;
						nxt.mode      = sws_pkg::MODE_SQ;
					end else if (ch == sws_pkg::CH_DQUOTE) begin
						nxt.word_open = 1'b1;
						nxt.mode      = sws_pkg::MODE_DQ;
					end else if (ch == sws_pkg::CH_BACKSLASH) begin
						nxt.word_open = 1'b1;
						nxt.mode      = sws_pkg::MODE_ESC;
					end else if (is_sep) begin
						if (cur.word_open) begin
							if (at_limit) begin
								nxt.error_code = sws_pkg::ST_TOO_MANY;
							end else begin
								res[0] = sws_pkg::make_result(sws_pkg::KIND_END, 8'd0,
									cur.word_count, sws_pkg::ST_OK, 1'b0);
								nxt.word_count = cur.word_count + 1'b1;
								nxt.word_open  = 1'b0;
							end
						end
					end else begin
						nxt.word_open = 1'b1;
						n = 2'd1;
					end
				end
			endcase
			// A word byte always lands in the first slot.
			if (n != 2'd0) begin
				res[0] = sws_pkg::make_result(sws_pkg::KIND_BYTE, ch, cur.word_count,
					sws_pkg::ST_OK, 1'b0);
			end
			if (res[0].kind == sws_pkg::KIND_END) begin
				n = 2'd1;
			end
		end
		res_cnt = n;
	end

endmodule

@@ design/shell_word_splitter.sv @@
// Shell word splitter: one command byte in per word, word bytes, word ends and status out.
// Results are registered: the first result appears in the cycle after its input word is accepted.
// Throughput: one byte word per cycle while out_ready is high; after a terminator (one to
// three results) the input waits until the single result queue port is draining its last.
// Reset (arst_n low, asynchronous) clears lexer state and drops queued results.
// Depends on sws_pkg and sws_lexer.
module shell_word_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        is_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [11:0] word_index,
	output logic [1:0]  status,
	output logic        last
);

	sws_pkg::lex_state_t  state_q;
	sws_pkg::lex_state_t  state_nxt;
	sws_pkg::result_t     lex_res [sws_pkg::MAX_RESULTS];
	logic [1:0]           lex_cnt;
	sws_pkg::result_t     res_q [sws_pkg::MAX_RESULTS];
	logic [1:0]           cnt_q;
	logic                 in_fire;
	logic                 out_fire;

	sws_lexer u_lexer (
		.ch      (ch),
		.is_end  (is_end),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (lex_res),
		.res_cnt (lex_cnt)
	);

	// Take a new word once the queue is empty or about to drain.
	assign in_ready  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_fire  = out_valid && out_ready;

	assign kind       = res_q[0].kind;
	assign out_byte   = res_q[0].out_byte;
	assign word_index = res_q[0].word_index;
	assign status     = res_q[0].status;
	assign last       = res_q[0].last;

	// Lexer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode       <= sws_pkg::MODE_PLAIN;
			state_q.word_open  <= 1'b0;
			state_q.word_count <= '0;
			state_q.error_code <= sws_pkg::ST_OK;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	// Result queue count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (in_fire) begin
			cnt_q <= lex_cnt;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Result queue payload: load on accept, shift toward the head on drain.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= lex_res;
		end else if (out_fire) begin
			for (int i = 0; i < sws_pkg::MAX_RESULTS - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

endmodule

@@ design/sws_checker.sv @@
// Port-level checks for the shell word splitter, attached by bind.
// Depends on sws_pkg for the result codes.
module sws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic [1:0]  kind,
	input logic [11:0] word_index,
	input logic [1:0]  status,
	input logic        last
);

	// The final result of a command is always the status word.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == sws_pkg::KIND_DONE)
		else $error("last set on a result that is not the status word");

	// Every status word closes its command.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == sws_pkg::KIND_DONE |-> last)
		else $error("status word without last");

	// A failed command reports a zero word count.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == sws_pkg::KIND_DONE && status != sws_pkg::ST_OK
		|-> word_index == '0)
		else $error("nonzero word count on a failed command");

	// Only the status word carries a status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != sws_pkg::KIND_DONE |-> status == sws_pkg::ST_OK)
		else $error("status set on a byte or word end");

endmodule

bind shell_word_splitter sws_checker u_sws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.kind       (kind),
	.word_index (word_index),
	.status     (status),
	.last       (last)
);
